FILE: design/lbo_pkg.sv
// ============================================================================
// lbo_pkg: shared types and constants for the layered box overlap sweep
// Holds the beat structs of both channels, the entry row layout, the
// control structs between the sequencer and the hit stage, and the codes.
// ============================================================================
package lbo_pkg;

    localparam int MAX_ENTRIES_DEF = 8;
    localparam int MAX_PAIRS_DEF   = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PCOUNT_W    = 3;

    localparam logic [2:0] MODE_REGISTER = 3'd0;
    localparam logic [2:0] MODE_REMOVE   = 3'd1;
    localparam logic [2:0] MODE_MOVE     = 3'd2;
    localparam logic [2:0] MODE_SWEEP    = 3'd3;
    localparam logic [2:0] MODE_CLEAR    = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_COUNT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAIR_LAYERS_0 = 3'd1;

    typedef struct packed {
        logic [2:0]         mode;
        logic [15:0]        box_id;
        logic [7:0]         box_layer;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [1:0]         pair_select;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  hit_pair;
        logic [15:0] first_id;
        logic [15:0] second_id;
        logic        last_hit;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         layer;
        logic [15:0]        ident;
        logic signed [15:0] xpos;
        logic signed [15:0] ypos;
        logic [15:0]        wide;
        logic [15:0]        tall;
    } row_t;

    typedef struct packed {
        logic [1:0]  hit_pair;
        logic [15:0] first_id;
        logic [15:0] second_id;
    } hit_t;

    typedef struct packed {
        logic push;
        logic flush;
        hit_t hit;
    } hit_ctl_t;

    typedef struct packed {
        logic room;
        logic pend_valid;
    } hit_sts_t;

endpackage

FILE: design/lbo_entry_ram.sv
// ============================================================================
// lbo_entry_ram: box entry table
// One write port and two read ports with registered read data. The read
// data registers hold their value while the read enable is low.
// ============================================================================
module lbo_entry_ram #(
    parameter int DEPTH = lbo_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  lbo_pkg::row_t wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output lbo_pkg::row_t rdata_a,
    output lbo_pkg::row_t rdata_b
);

    lbo_pkg::row_t entry_mem_reg [DEPTH];
    lbo_pkg::row_t rd_a_reg;
    lbo_pkg::row_t rd_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            entry_mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_a_reg <= entry_mem_reg[raddr_a];
            rd_b_reg <= entry_mem_reg[raddr_b];
        end
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

FILE: design/lbo_hit_stage.sv
// ============================================================================
// lbo_hit_stage: hit holding register and result output register
// A hit waits in the holding register until either a newer hit arrives
// (it leaves as a normal beat) or the sweep ends (it leaves as the last beat).
// ============================================================================
module lbo_hit_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  lbo_pkg::hit_ctl_t  hit_ctl,
    output lbo_pkg::hit_sts_t  hit_sts,
    output logic               m_valid,
    input  logic               m_ready,
    output lbo_pkg::out_item_t m_data
);

    logic               pend_valid_reg, pend_valid_next;
    lbo_pkg::hit_t      pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    lbo_pkg::out_item_t out_reg, out_next;
    logic               out_free;
    logic               load_out;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        load_out        = 1'b0;
        if (hit_ctl.push) begin
            if (pend_valid_reg) begin
                load_out = 1'b1;
                out_next = '{hit_pair: pend_reg.hit_pair, first_id: pend_reg.first_id,
                             second_id: pend_reg.second_id, last_hit: 1'b0};
            end
            pend_next       = hit_ctl.hit;
            pend_valid_next = 1'b1;
        end else if (hit_ctl.flush && pend_valid_reg && out_free) begin
            load_out        = 1'b1;
            out_next        = '{hit_pair: pend_reg.hit_pair, first_id: pend_reg.first_id,
                                second_id: pend_reg.second_id, last_hit: 1'b1};
            pend_valid_next = 1'b0;
        end
        out_valid_next = load_out || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    assign hit_sts.room       = !pend_valid_reg || out_free;
    assign hit_sts.pend_valid = pend_valid_reg;
    assign m_valid            = out_valid_reg;
    assign m_data             = out_reg;

endmodule

FILE: design/lbo_sequencer.sv
// ============================================================================
// lbo_sequencer: command decode and table walker
// Takes input beats, edits the entry table by read-modify-write passes and
// drives the sweep pipeline: address issue, then overlap compare on the
// registered read data.
// ============================================================================
module lbo_sequencer #(
    parameter int MAX_ENTRIES = lbo_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_PAIRS   = lbo_pkg::MAX_PAIRS_DEF,
    parameter int AW          = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lbo_pkg::in_item_t             s_data,
    input  logic [lbo_pkg::PCOUNT_W-1:0]  pair_count,
    input  logic [MAX_PAIRS-1:0][15:0]    pair_layers,
    input  lbo_pkg::hit_sts_t             hit_sts,
    output lbo_pkg::hit_ctl_t             hit_ctl,
    output logic                          we,
    output logic [AW-1:0]                 waddr,
    output lbo_pkg::row_t                 wdata,
    output logic                          re,
    output logic [AW-1:0]                 raddr_a,
    output logic [AW-1:0]                 raddr_b,
    input  lbo_pkg::row_t                 rdata_a,
    input  lbo_pkg::row_t                 rdata_b
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REMOVE = 3'd1;
    localparam logic [2:0] ST_MOVE   = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] wr_ptr_reg, wr_ptr_next;
    logic          s1_valid_reg, s1_valid_next;
    logic [AW-1:0] s1_idx_reg, s1_idx_next;
    logic [15:0]   key_reg, key_next;
    logic [15:0]   cx_reg, cx_next;
    logic [15:0]   cy_reg, cy_next;
    logic [7:0]    la_reg, la_next;
    logic [7:0]    lb_reg, lb_next;
    logic [1:0]    sel_reg, sel_next;

    logic          accept;
    logic          full;
    logic [15:0]   sel_layers;
    logic [lbo_pkg::PCOUNT_W-1:0] enabled_cnt;
    logic          pair_on;
    logic          issue;
    logic          advance;
    logic          s1_hit;
    logic [16:0]   dx, dy, adx, ady;
    logic [16:0]   wsum, hsum;
    logic          overlap;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CW'(MAX_ENTRIES));

    always_comb begin
        sel_layers = '0;
        for (int p = 0; p < MAX_PAIRS; p++) begin
            if (s_data.pair_select == 2'(p)) begin
                sel_layers = pair_layers[p];
            end
        end
    end

    assign enabled_cnt = (pair_count > lbo_pkg::PCOUNT_W'(MAX_PAIRS)) ?
                         lbo_pkg::PCOUNT_W'(MAX_PAIRS) : pair_count;
    assign pair_on     = ({1'b0, s_data.pair_select} < enabled_cnt);

    // Exact doubled compare: 2|dx| < w1 + w2 and 2|dy| < h1 + h2.
    assign dx      = {rdata_a.xpos[15], rdata_a.xpos} - {rdata_b.xpos[15], rdata_b.xpos};
    assign dy      = {rdata_a.ypos[15], rdata_a.ypos} - {rdata_b.ypos[15], rdata_b.ypos};
    assign adx     = dx[16] ? (17'd0 - dx) : dx;
    assign ady     = dy[16] ? (17'd0 - dy) : dy;
    assign wsum    = {1'b0, rdata_a.wide} + {1'b0, rdata_b.wide};
    assign hsum    = {1'b0, rdata_a.tall} + {1'b0, rdata_b.tall};
    assign overlap = ({adx, 1'b0} < {1'b0, wsum}) && ({ady, 1'b0} < {1'b0, hsum});

    assign s1_hit  = s1_valid_reg && (rdata_a.layer == la_reg) &&
                     (rdata_b.layer == lb_reg) && overlap;
    assign advance = !s1_hit || hit_sts.room;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        wr_ptr_next   = wr_ptr_reg;
        s1_valid_next = s1_valid_reg;
        s1_idx_next   = s1_idx_reg;
        key_next      = key_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        la_next       = la_reg;
        lb_next       = lb_reg;
        sel_next      = sel_reg;
        issue         = 1'b0;
        hit_ctl.push  = 1'b0;
        hit_ctl.flush = 1'b0;
        hit_ctl.hit   = '{hit_pair: sel_reg, first_id: rdata_a.ident,
                          second_id: rdata_b.ident};
        we            = 1'b0;
        waddr         = count_reg[AW-1:0];
        wdata         = '{layer: s_data.box_layer, ident: s_data.box_id,
                          xpos: s_data.center_x, ypos: s_data.center_y,
                          wide: s_data.box_width, tall: s_data.box_height};

        unique case (state_reg) inside
            ST_IDLE: begin
                if (accept) begin
                    key_next      = s_data.box_id;
                    cx_next       = s_data.center_x;
                    cy_next       = s_data.center_y;
                    la_next       = sel_layers[15:8];
                    lb_next       = sel_layers[7:0];
                    sel_next      = s_data.pair_select;
                    i_next        = '0;
                    j_next        = '0;
                    wr_ptr_next   = '0;
                    s1_valid_next = 1'b0;
                    unique case (s_data.mode)
                        lbo_pkg::MODE_REGISTER: begin
                            if (!full) begin
                                we         = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        lbo_pkg::MODE_REMOVE: state_next = ST_REMOVE;
                        lbo_pkg::MODE_MOVE:   state_next = ST_MOVE;
                        lbo_pkg::MODE_SWEEP: begin
                            if (pair_on) begin
                                state_next = ST_SWEEP;
                            end
                        end
                        lbo_pkg::MODE_CLEAR:  count_next = '0;
                        default: ;
                    endcase
                end
            end
            ST_REMOVE, ST_MOVE: begin
                // The write pointer never passes the entry under compare, so the
                // write-back cannot hit an address that is still to be read.
                issue         = (i_reg < count_reg);
                s1_valid_next = issue;
                s1_idx_next   = i_reg[AW-1:0];
                if (issue) begin
                    i_next = i_reg + 1'b1;
                end
                if (s1_valid_reg) begin
                    if (state_reg == ST_REMOVE) begin
                        if (rdata_a.ident != key_reg) begin
                            we          = 1'b1;
                            waddr       = wr_ptr_reg[AW-1:0];
                            wdata       = rdata_a;
                            wr_ptr_next = wr_ptr_reg + 1'b1;
                        end
                    end else if (rdata_a.ident == key_reg) begin
                        we         = 1'b1;
                        waddr      = s1_idx_reg;
                        wdata      = rdata_a;
                        wdata.xpos = cx_reg;
                        wdata.ypos = cy_reg;
                    end
                end
                if (!issue && !s1_valid_reg) begin
                    state_next = ST_IDLE;
                    if (state_reg == ST_REMOVE) begin
                        count_next = wr_ptr_reg;
                    end
                end
            end
            ST_SWEEP: begin
                // A hit that cannot be absorbed freezes the compare stage and the
                // read data registers until the hit stage has room.
                if (advance) begin
                    issue         = (i_reg < count_reg);
                    s1_valid_next = issue;
                    hit_ctl.push  = s1_hit;
                    if (issue) begin
                        if (CW'(j_reg + 1'b1) == count_reg) begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                hit_ctl.flush = 1'b1;
                if (!hit_sts.pend_valid) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign re      = issue;
    assign raddr_a = i_reg[AW-1:0];
    assign raddr_b = j_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        wr_ptr_reg <= wr_ptr_next;
        s1_idx_reg <= s1_idx_next;
        key_reg    <= key_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        la_reg     <= la_next;
        lb_reg     <= lb_next;
        sel_reg    <= sel_next;
    end

endmodule

FILE: design/layered_box_overlap_sweep.sv
// ============================================================================
// layered_box_overlap_sweep: box table with layer pair overlap sweeps
// Keeps up to MAX_ENTRIES boxes in an entry memory and reports every
// overlapping pair of a configured layer pair, one beat per hit.
// ============================================================================
//
//   Channel  Ports                          Beat
//   -------  -----------------------------  ------------------------------
//   input    s_valid, s_ready, s_data       one command (in_item_t)
//   result   m_valid, m_ready, m_data       one overlap hit (out_item_t)
//   config   cfg_we, cfg_index, cfg_wdata   one register write
//
// Register, clear and unknown commands complete in the cycle they are accepted.
// Remove and move make one pass over the n stored entries, one memory read
// per cycle. A sweep reads all n * n ordered entry pairs, one pair per cycle
// on the two memory read ports while no hit waits for room in the hit stage.
// Reset is synchronous and empties the table by clearing the entry count.
// A stalled result holds the compare pipeline only when a new hit finds no
// room.
//
module layered_box_overlap_sweep #(
    parameter int MAX_ENTRIES = lbo_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_PAIRS   = lbo_pkg::MAX_PAIRS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lbo_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lbo_pkg::out_item_t                m_data,
    input  logic                              cfg_we,
    input  logic [lbo_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lbo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [lbo_pkg::PCOUNT_W-1:0] pair_count_reg;
    logic [MAX_PAIRS-1:0][15:0]   pair_layers_reg;

    lbo_pkg::hit_ctl_t hit_ctl;
    lbo_pkg::hit_sts_t hit_sts;
    logic              we;
    logic [AW-1:0]     waddr;
    lbo_pkg::row_t     wdata;
    logic              re;
    logic [AW-1:0]     raddr_a;
    logic [AW-1:0]     raddr_b;
    lbo_pkg::row_t     rdata_a;
    lbo_pkg::row_t     rdata_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_count_reg  <= '0;
            pair_layers_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == lbo_pkg::CFG_PAIR_COUNT) begin
                pair_count_reg <= cfg_wdata[lbo_pkg::PCOUNT_W-1:0];
            end
            for (int p = 0; p < MAX_PAIRS; p++) begin
                if (cfg_index == lbo_pkg::CFG_INDEX_W'(lbo_pkg::CFG_PAIR_LAYERS_0 + p)) begin
                    pair_layers_reg[p] <= cfg_wdata[15:0];
                end
            end
        end
    end

    lbo_sequencer #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_PAIRS   (MAX_PAIRS),
        .AW          (AW)
    ) u_sequencer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .pair_count  (pair_count_reg),
        .pair_layers (pair_layers_reg),
        .hit_sts     (hit_sts),
        .hit_ctl     (hit_ctl),
        .we          (we),
        .waddr       (waddr),
        .wdata       (wdata),
        .re          (re),
        .raddr_a     (raddr_a),
        .raddr_b     (raddr_b),
        .rdata_a     (rdata_a),
        .rdata_b     (rdata_b)
    );

    lbo_entry_ram #(
        .DEPTH   (MAX_ENTRIES),
        .AW      (AW)
    ) u_entry_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    lbo_hit_stage u_hit_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .hit_ctl (hit_ctl),
        .hit_sts (hit_sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: design/lbo_checker.sv
// ============================================================================
// lbo_checker: port-level assertions for the overlap sweep block
// Watches the handshake ports of the top level and checks timing relations
// between commands and result beats. Attached to the top level by bind.
// ============================================================================
module lbo_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input lbo_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input lbo_pkg::out_item_t m_data
);

    // A result beat that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // While a beat that is not the last of its sweep waits, the sweep is still open.
    a_sweep_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_hit |-> !s_ready)
        else $error("input accepted while a sweep still has hits pending");

    // Register and clear finish in the cycle they are accepted.
    a_quick_edit: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        (s_data.mode == lbo_pkg::MODE_REGISTER || s_data.mode == lbo_pkg::MODE_CLEAR)
        |=> s_ready)
        else $error("register or clear did not return to idle");

    // Reset drops any result beat.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind layered_box_overlap_sweep lbo_checker u_lbo_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
